/* hdl/tbd_pkg.sv */
// ============================================================================
// tbd_pkg
// Shared types and constants of the tremor band detector: register indexes,
// register reset values and the sequencer state encoding.
// ============================================================================
`default_nettype none

package tbd_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_SCALE_FACTOR      = 3'd0;
    localparam logic [2:0] REG_PROCESS_NOISE     = 3'd1;
    localparam logic [2:0] REG_MEASUREMENT_NOISE = 3'd2;
    localparam logic [2:0] REG_PEAK_THRESHOLD    = 3'd3;
    localparam logic [2:0] REG_WINDOW_LENGTH     = 3'd4;
    localparam logic [2:0] REG_MIN_PEAK_GAP      = 3'd5;
    localparam logic [2:0] REG_BAND_LOW_PEAKS    = 3'd6;
    localparam logic [2:0] REG_BAND_HIGH_PEAKS   = 3'd7;

    // Register reset values
    localparam logic [23:0]        RST_SCALE_FACTOR      = 24'd5124;
    localparam logic [31:0]        RST_PROCESS_NOISE     = 32'd1677722;
    localparam logic [31:0]        RST_MEASUREMENT_NOISE = 32'd419430400;
    localparam logic signed [31:0] RST_PEAK_THRESHOLD    = 32'sd838861;
    localparam logic [11:0]        RST_WINDOW_LENGTH     = 12'd800;
    localparam logic [11:0]        RST_MIN_PEAK_GAP      = 12'd10;
    localparam logic [10:0]        RST_BAND_LOW_PEAKS    = 11'd6;
    localparam logic [10:0]        RST_BAND_HIGH_PEAKS   = 11'd12;

    // Peak counter saturation
    localparam logic [10:0] CNT_MAX = 11'd2047;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_VAR   = 7'b0000010,
        S_DINIT = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_MULG  = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_VUPD  = 7'b1000000
    } t_state;

endpackage : tbd_pkg

`default_nettype wire

/* hdl/tremor_band_detector.sv */
// An accepted sample steps through S_VAR, S_DINIT, S_DIV, S_MULG, S_UPD and
// S_VUPD; m_axis_tvalid is registered from the result load in S_VUPD.
// s_axis_tready is high only while the sequencer is idle, so a new sample is
// taken only once the last one has left S_VUPD. The gain divider produces one
// quotient bit per cycle; one shared multiplier does the three products.
// Reset (i_rst_n low, synchronous): registers back to defaults, estimate 0,
// variance 1.0, window restarted, output beat dropped.
// ============================================================================
// tremor_band_detector
// Scalar Kalman smoothing of gyro rate samples with windowed peak counting
// and band classification, built around one shared multiplier and a serial
// restoring divider under a small sequencer.
// ============================================================================
`default_nettype none

module tremor_band_detector #(
    parameter int FRAC_BITS  = 24,
    parameter int INDEX_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // sample input; tdata: [15:0] raw_rate
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,
    // result output; tdata: [31:0] filtered_rate, [42:32] peak_count,
    // [43] in_band, [44] above_band, [47:45] zero; tlast: window_done
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    import tbd_pkg::*;

    // ------------------------------------------------------------------
    // Derived widths and constants
    // ------------------------------------------------------------------
    localparam int GW  = FRAC_BITS + 1;          // gain, Q1.F up to 1.0
    localparam int MBW = FRAC_BITS + 2;          // multiplier B operand
    localparam int PW  = 33 + MBW;               // product width
    localparam int SW  = $clog2(FRAC_BITS + 1);  // divider step counter
    localparam int CW  = (INDEX_BITS > 12) ? INDEX_BITS : 12;
    localparam int LW  = CW + 2;

    localparam logic [GW-1:0] ONE_Q = GW'(1) << FRAC_BITS;
    localparam logic [31:0]   EV_RESET = 32'(1) << FRAC_BITS;
    localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;
    localparam logic [LW-1:0] LEN_MIN = LW'(3);
    localparam logic [LW-1:0] LEN_MAX = LW'(1) << INDEX_BITS;
    localparam logic [SW-1:0] LAST_STEP = SW'(FRAC_BITS);
    localparam logic signed [PW-1:0] P_MAX = PW'(64'sd2147483647);
    localparam logic signed [PW-1:0] P_MIN = -P_MAX - PW'(1);

    function automatic logic signed [31:0] sat_q32(input logic signed [PW-1:0] v);
        logic signed [31:0] r;
        if (v > P_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < P_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [23:0]        r_sf;
    logic [31:0]        r_pn, r_mn;
    logic signed [31:0] r_thr;
    logic [11:0]        r_wl, r_gap;
    logic [10:0]        r_lo, r_hi;

    logic signed [15:0] r_raw;
    logic [31:0]        r_var;
    logic [32:0]        r_den;
    logic [33:0]        r_rem;
    logic [GW-1:0]      r_quo;
    logic [SW-1:0]      r_step;
    logic               r_first;
    logic signed [31:0] r_meas;
    logic signed [32:0] r_err;
    logic signed [PW-1:0] r_prod;

    logic signed [31:0] r_est;
    logic [31:0]        r_ev;
    logic signed [31:0] r_older, r_newer;
    logic [INDEX_BITS-1:0] r_idx, r_since;
    logic [10:0]        r_cnt, r_last;
    logic [1:0]         r_flags;

    logic               r_ovalid;
    logic signed [31:0] r_orate;
    logic               r_odone;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_fire, out_load;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_VUPD) && (!r_ovalid || m_axis_tready);

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_odone;
    assign m_axis_tdata  = {3'b000, r_flags[1], r_flags[0], r_last, r_orate};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf  <= RST_SCALE_FACTOR;
            r_pn  <= RST_PROCESS_NOISE;
            r_mn  <= RST_MEASUREMENT_NOISE;
            r_thr <= RST_PEAK_THRESHOLD;
            r_wl  <= RST_WINDOW_LENGTH;
            r_gap <= RST_MIN_PEAK_GAP;
            r_lo  <= RST_BAND_LOW_PEAKS;
            r_hi  <= RST_BAND_HIGH_PEAKS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SCALE_FACTOR:      r_sf  <= i_cfg_data[23:0];
                REG_PROCESS_NOISE:     r_pn  <= i_cfg_data;
                REG_MEASUREMENT_NOISE: r_mn  <= i_cfg_data;
                REG_PEAK_THRESHOLD:    r_thr <= i_cfg_data;
                REG_WINDOW_LENGTH:     r_wl  <= i_cfg_data[11:0];
                REG_MIN_PEAK_GAP:      r_gap <= i_cfg_data[11:0];
                REG_BAND_LOW_PEAKS:    r_lo  <= i_cfg_data[10:0];
                REG_BAND_HIGH_PEAKS:   r_hi  <= i_cfg_data[10:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: operand select by state, product registered
    // ------------------------------------------------------------------
    logic [GW-1:0]        gain_v, one_m_gain;
    logic signed [32:0]   mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;

    assign gain_v     = (r_den == 33'd0) ? '0 : r_quo;
    assign one_m_gain = ONE_Q - gain_v;

    always_comb begin
        mul_a = $signed({9'd0, r_sf});
        mul_b = MBW'(r_raw);
        case (r_state)
            S_MULG: begin
                mul_a = r_err;
                mul_b = $signed({1'b0, gain_v});
            end
            S_UPD: begin
                mul_a = $signed({1'b0, r_var});
                mul_b = $signed({1'b0, one_m_gain});
            end
            default: begin
                mul_a = $signed({9'd0, r_sf});
                mul_b = MBW'(r_raw);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Divider step and estimate update
    // ------------------------------------------------------------------
    logic [33:0] div_t;
    logic        div_ge;
    logic [32:0] var_sum;
    logic signed [PW-1:0] est_sum;

    assign div_t   = r_first ? r_rem : {r_rem[32:0], 1'b0};
    assign div_ge  = div_t >= {1'b0, r_den};
    assign var_sum = {1'b0, r_ev} + {1'b0, r_pn};
    assign est_sum = PW'(r_est) + (r_prod >>> FRAC_BITS);

    // ------------------------------------------------------------------
    // Peak detection and window bookkeeping
    // ------------------------------------------------------------------
    logic                  is_peak, done;
    logic [INDEX_BITS-1:0] since_a, since_b;
    logic [10:0]           cnt_a;
    logic [LW-1:0]         len_c, idx_p1;

    always_comb begin
        is_peak = (r_idx >= INDEX_BITS'(2)) && (r_newer > r_older) &&
                  (r_newer > r_est) && (r_newer > r_thr) &&
                  (CW'(r_since) >= CW'(r_gap));
        since_a = is_peak ? '0 : r_since;
        since_b = (since_a < IDX_MAX) ? since_a + INDEX_BITS'(1) : since_a;
        cnt_a   = (is_peak && (r_cnt < CNT_MAX)) ? r_cnt + 11'd1 : r_cnt;
        len_c   = (LW'(r_wl) < LEN_MIN) ? LEN_MIN : LW'(r_wl);
        if (len_c > LEN_MAX) begin
            len_c = LEN_MAX;
        end
        idx_p1  = LW'(r_idx) + LW'(1);
        done    = idx_p1 >= len_c;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_fire) n_state = S_VAR;
            S_VAR:   n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV:   if (r_step == LAST_STEP) n_state = S_MULG;
            S_MULG:  n_state = S_UPD;
            S_UPD:   n_state = S_VUPD;
            S_VUPD:  if (out_load) n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_raw <= s_axis_tdata;
        end
        case (r_state) inside
            S_VAR: begin
                r_var  <= var_sum[32] ? 32'hffffffff : var_sum[31:0];
                r_prod <= mul_p;
            end
            S_DINIT: begin
                r_meas  <= sat_q32(r_prod);
                r_den   <= {1'b0, r_var} + {1'b0, r_mn};
                r_rem   <= {2'b00, r_var};
                r_step  <= '0;
                r_first <= 1'b1;
            end
            S_DIV: begin
                r_err   <= {r_meas[31], r_meas} - {r_est[31], r_est};
                r_rem   <= div_ge ? div_t - {1'b0, r_den} : div_t;
                r_quo   <= {r_quo[GW-2:0], div_ge};
                r_step  <= r_step + SW'(1);
                r_first <= 1'b0;
            end
            S_MULG, S_UPD: begin
                r_prod <= mul_p;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Filter and window state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est   <= '0;
            r_ev    <= EV_RESET;
            r_older <= '0;
            r_newer <= '0;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_since <= IDX_MAX;
            r_last  <= '0;
            r_flags <= '0;
        end else begin
            if (r_state == S_UPD) begin
                r_est <= sat_q32(est_sum);
            end
            if (out_load) begin
                r_ev    <= r_prod[FRAC_BITS +: 32];
                r_older <= r_newer;
                r_newer <= r_est;
                if (done) begin
                    r_last     <= cnt_a;
                    r_flags[0] <= (cnt_a >= r_lo) && (cnt_a <= r_hi);
                    r_flags[1] <= cnt_a > r_hi;
                    r_idx      <= '0;
                    r_cnt      <= '0;
                    r_since    <= IDX_MAX;
                end else begin
                    r_idx   <= r_idx + INDEX_BITS'(1);
                    r_cnt   <= cnt_a;
                    r_since <= since_b;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_orate <= r_est;
            r_odone <= done;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_VAR))
        else $error("accepted sample did not start the sequence");

    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULG) |-> (gain_v <= ONE_Q))
        else $error("Kalman gain above one");

    a_var_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_prod[FRAC_BITS +: 32] <= r_var))
        else $error("updated variance exceeds predicted variance");

    a_window_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && done) |=> ((r_idx == '0) && (r_cnt == '0) && (r_since == IDX_MAX)))
        else $error("window did not restart after closing");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready && (r_state == S_VUPD)) |=> (r_state == S_VUPD))
        else $error("result overwrote a pending output beat");

endmodule : tremor_band_detector

`default_nettype wire
